@@ rtl/core/psms_pkg.sv @@
// Shared types, constants and index helpers of the packed special matrix store.
`default_nettype none
package psms_pkg;

   localparam int MAX_DIM     = 16;
   localparam int STORE_DEPTH = (MAX_DIM * (MAX_DIM + 1)) / 2;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int BAND_STRIDE = 2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [4:0]       dim_type;
   typedef logic [2:0]       kind_type;
   typedef logic [1:0]       op_type;

   localparam kind_type KIND_DIAG  = 3'd0;
   localparam kind_type KIND_LOWER = 3'd1;
   localparam kind_type KIND_UPPER = 3'd2;
   localparam kind_type KIND_SYMM  = 3'd3;
   localparam kind_type KIND_TRIDI = 3'd4;

   localparam op_type OP_INSERT  = 2'd0;
   localparam op_type OP_SEARCH  = 2'd1;
   localparam op_type OP_REMOVE  = 2'd2;
   localparam op_type OP_REPLACE = 2'd3;

   localparam logic CSR_KIND = 1'b0;
   localparam logic CSR_DIM  = 1'b1;

   typedef struct packed {
      op_type             operation;
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [31:0] value;
      logic signed [31:0] new_value;
   } req_type;

   typedef struct packed {
      logic status;
      logic found;
   } rsp_type;

   typedef struct packed {
      logic    ok;
      idx_type idx;
   } cell_type;

   // Dimension clamped into the range one to MAX_DIM.
   function automatic dim_type eff_dim(input dim_type dim);
      dim_type d;
      d = dim;
      if (d == dim_type'(0)) d = dim_type'(1);
      if (int'(d) > MAX_DIM) d = dim_type'(MAX_DIM);
      return d;
   endfunction

   // Packed position of a cell in a lower triangle, row hi and column lo.
   function automatic idx_type tri_index(input logic [3:0] hi, input logic [3:0] lo);
      logic [8:0] prod;
      prod = {5'b0, hi} * ({5'b0, hi} + 9'd1);
      return idx_type'(prod >> 1) + idx_type'(lo);
   endfunction

   function automatic cnt_type used_entries(input kind_type kind, input dim_type dim);
      dim_type    d;
      logic [9:0] prod;
      d    = eff_dim(dim);
      prod = {5'b0, d} * ({5'b0, d} + 10'd1);
      case (kind)
         KIND_DIAG:  return cnt_type'(d);
         KIND_LOWER,
         KIND_UPPER,
         KIND_SYMM:  return cnt_type'(prod >> 1);
         KIND_TRIDI: return cnt_type'(d) * cnt_type'(3) - cnt_type'(2);
         default:    return cnt_type'(0);
      endcase
   endfunction

   // Validity and packed position of cell (i, j) for the given kind.
   function automatic cell_type cell_index(input kind_type kind, input dim_type dim,
                                           input logic [3:0] i, input logic [3:0] j);
      cell_type c;
      dim_type  d;
      logic     in_range;
      d        = eff_dim(dim);
      in_range = ({1'b0, i} < d) && ({1'b0, j} < d);
      c.ok     = 1'b0;
      c.idx    = '0;
      case (kind)
         KIND_DIAG: begin
            c.ok  = (i == j);
            c.idx = idx_type'(i);
         end
         KIND_LOWER: begin
            c.ok  = (i >= j);
            c.idx = tri_index(i, j);
         end
         KIND_UPPER: begin
            c.ok  = (j >= i);
            c.idx = tri_index(j, i);
         end
         KIND_SYMM: begin
            c.ok  = 1'b1;
            c.idx = (i >= j) ? tri_index(i, j) : tri_index(j, i);
         end
         KIND_TRIDI: begin
            c.ok  = (i == j) || ({1'b0, i} == {1'b0, j} + 5'd1) ||
                    ({1'b0, j} == {1'b0, i} + 5'd1);
            c.idx = idx_type'(BAND_STRIDE) * idx_type'(i) + idx_type'(j);
         end
         default: begin
            c.ok  = 1'b0;
            c.idx = '0;
         end
      endcase
      c.ok = c.ok && in_range && (int'(c.idx) < STORE_DEPTH);
      return c;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/packed_special_matrix_store_core.sv @@
// Top level of the packed special matrix store: control, packed store and scan pipeline.
`default_nettype none
// The block keeps one square matrix (diagonal, lower or upper triangular, symmetric or
// tridiagonal) in a packed store of MAX_DIM*(MAX_DIM+1)/2 words with one read port, one
// write port and registered read data. An item is taken on a clock edge with start
// high and busy low; its result appears on rsp_payload for exactly one cycle with
// rsp_strobe high, and the receiver cannot hold it off. An insert passes through the
// insert state, with busy high, and its result is registered as the block returns to idle.
// Search, remove and replace walk the entries in use (diagonal: dimension; triangular and
// symmetric: dimension*(dimension+1)/2; tridiagonal: 3*dimension-2) at one store read per
// cycle; busy stays high until the last word read has been compared, and the result
// is registered as the block returns to idle. Each read word is compared in the
// following cycle and written back at once when it matches, so one read port and one
// write port on the store set the pace.
// Per-entry valid bits make unwritten words read as zero, so reset and configuration
// writes clear the matrix at once, with no clearing pass. Configuration must be written
// only while the block is idle; a write to either register clears the matrix.
module packed_special_matrix_store_core (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  psms_pkg::req_type   req_payload,
   output logic                rsp_strobe,
   output psms_pkg::rsp_type   rsp_payload,
   input  wire                 csr_we,
   input  wire                 csr_index,
   input  wire  [4:0]          csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_INSERT = 3'b010,
      ST_SCAN   = 3'b100
   } state_type;

   state_type                       state_ff, state_in;
   psms_pkg::req_type               item_ff;
   psms_pkg::kind_type              kind_ff;
   psms_pkg::dim_type               dim_ff;
   logic [psms_pkg::STORE_DEPTH-1:0] valid_ff;

   psms_pkg::cnt_type               rd_ff, rd_in;
   logic                            p_vld_ff, p_vld_in;
   psms_pkg::idx_type               p_idx_ff;
   logic [31:0]                     rd_data_ff;
   logic                            found_ff, found_in;

   logic                            rsp_strobe_ff, rsp_strobe_in;
   psms_pkg::rsp_type               rsp_ff, rsp_in;

   logic [31:0]                     store_mem [psms_pkg::STORE_DEPTH];

   psms_pkg::cnt_type               used;
   psms_pkg::cell_type              cell_info;
   logic                            accept;
   logic                            issue;
   logic [31:0]                     cur_word;
   logic                            hit;
   logic                            wr_en;
   psms_pkg::idx_type               wr_idx;
   logic [31:0]                     wr_data;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign used      = psms_pkg::used_entries(kind_ff, dim_ff);
   assign cell_info = psms_pkg::cell_index(kind_ff, dim_ff, item_ff.row, item_ff.col);

   // A read is issued while unread entries in use remain.
   assign issue = (state_ff == ST_SCAN) && (rd_ff < used);

   // An entry that was never written since the last clear reads as zero.
   assign cur_word = valid_ff[p_idx_ff] ? rd_data_ff : 32'd0;
   assign hit      = p_vld_ff && (cur_word == item_ff.value);

   always_comb begin
      state_in      = state_ff;
      rd_in         = rd_ff;
      p_vld_in      = 1'b0;
      found_in      = found_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_idx        = cell_info.idx;
      wr_data       = item_ff.value;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_payload.operation == psms_pkg::OP_INSERT) ? ST_INSERT : ST_SCAN;
               rd_in    = '0;
               found_in = 1'b0;
            end
         end
         ST_INSERT: begin
            wr_en         = cell_info.ok;
            rsp_strobe_in = 1'b1;
            rsp_in.status = !cell_info.ok;
            rsp_in.found  = 1'b0;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            p_vld_in = issue;
            if (issue) begin
               rd_in = rd_ff + psms_pkg::cnt_type'(1);
            end
            // The word read in the previous cycle is compared and written back here.
            wr_idx = p_idx_ff;
            if (hit) begin
               found_in = 1'b1;
               case (item_ff.operation)
                  psms_pkg::OP_REMOVE: begin
                     wr_en   = 1'b1;
                     wr_data = 32'd0;
                  end
                  psms_pkg::OP_REPLACE: begin
                     wr_en   = 1'b1;
                     wr_data = item_ff.new_value;
                  end
                  default: begin
                     wr_en = 1'b0;
                  end
               endcase
            end
            if (!issue) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = 1'b0;
               rsp_in.found  = (item_ff.operation == psms_pkg::OP_SEARCH) && (found_ff || hit);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         kind_ff       <= psms_pkg::KIND_DIAG;
         dim_ff        <= psms_pkg::dim_type'(psms_pkg::MAX_DIM);
         valid_ff      <= '0;
         p_vld_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         p_vld_ff      <= p_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            case (csr_index)
               psms_pkg::CSR_KIND: kind_ff <= csr_wdata[2:0];
               psms_pkg::CSR_DIM:  dim_ff  <= csr_wdata;
               default: ;
            endcase
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
      rd_ff    <= rd_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
      if (issue) begin
         p_idx_ff <= rd_ff[psms_pkg::IDX_W-1:0];
      end
   end

   // Packed store: one read and one write per cycle, registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_idx] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= store_mem[rd_ff[psms_pkg::IDX_W-1:0]];
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // An accepted item always makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("accepted item did not raise busy");

   // A result only follows a cycle of work.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> $past(busy))
      else $error("result without a preceding busy cycle");

   // The compare stage only carries data while a scan is running.
   assert property (@(posedge clock) disable iff (reset) p_vld_ff |-> (state_ff == ST_SCAN))
      else $error("scan pipeline holds data outside a scan");

   // Only a search can report a find.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.found) |-> (item_ff.operation == psms_pkg::OP_SEARCH))
      else $error("found set for an operation other than search");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the packed special matrix store core.
`timescale 1ns / 1ps

// The testbench drives items through the start/busy command port. Results come
// back on a single-cycle strobe that cannot be held off. A small scoreboard class
// keeps its own copy of the packed store and of the two configuration registers.
// It works out the status and found bits for every accepted transfer and checks
// each strobed result against the oldest expectation in order.
module tb;
   import psms_pkg::*;

   localparam int TOTAL_ITEMS = 850;     // no new phase starts once this many have gone in
   localparam int CALM_ITEMS  = 120;     // the closing stretch runs without sender gaps
   localparam int CYCLE_LIMIT = 600000;  // several times the slowest legal run

   // Scoreboard: predicts the block and checks its results in order.
   class psms_scoreboard;
      logic [31:0] cells [STORE_DEPTH];
      kind_type    kind;
      dim_type     dim;
      rsp_type     awaited [$];
      int          fail_count;

      function new();
         kind       = KIND_DIAG;
         dim        = dim_type'(MAX_DIM);
         fail_count = 0;
         clear_cells();
      endfunction

      function void clear_cells();
         foreach (cells[k]) cells[k] = '0;
      endfunction

      // A write to either register clears the whole matrix.
      function void write_register(logic index, logic [4:0] data);
         if (index == CSR_KIND) kind = data[2:0];
         else dim = data;
         clear_cells();
      endfunction

      function int unsigned clamp_dim();
         int unsigned d;
         d = dim;
         if (d < 1) d = 1;
         if (d > MAX_DIM) d = MAX_DIM;
         return d;
      endfunction

      function int unsigned entries_in_use();
         int unsigned d, n;
         d = clamp_dim();
         case (kind)
            KIND_DIAG:  n = d;
            KIND_LOWER,
            KIND_UPPER,
            KIND_SYMM:  n = d * (d + 1) / 2;
            KIND_TRIDI: n = 3 * d - 2;
            default:    n = 0;
         endcase
         if (n > STORE_DEPTH) n = STORE_DEPTH;
         return n;
      endfunction

      // Returns 1 and the packed position when the cell lies on the kind's pattern.
      function bit locate_cell(input int unsigned i, input int unsigned j,
                               output int unsigned pos);
         int unsigned d, gap;
         d   = clamp_dim();
         pos = 0;
         if (i >= d || j >= d) return 1'b0;
         case (kind)
            KIND_DIAG: begin
               pos = i;
               return i == j;
            end
            KIND_LOWER: begin
               pos = i * (i + 1) / 2 + j;
               return i >= j;
            end
            KIND_UPPER: begin
               pos = j * (j + 1) / 2 + i;
               return j >= i;
            end
            KIND_SYMM: begin
               pos = (i >= j) ? i * (i + 1) / 2 + j : j * (j + 1) / 2 + i;
               return 1'b1;
            end
            KIND_TRIDI: begin
               gap = (i > j) ? i - j : j - i;
               pos = BAND_STRIDE * i + j;
               return gap <= 1;
            end
            default: return 1'b0;
         endcase
      endfunction

      // Applies one accepted item to the local store and queues its result.
      function void note_request(req_type r);
         rsp_type     want;
         int unsigned pos, n, k;
         n    = entries_in_use();
         want = '0;
         case (r.operation)
            OP_INSERT: begin
               if (locate_cell(r.row, r.col, pos) && pos < STORE_DEPTH) cells[pos] = r.value;
               else want.status = 1'b1;
            end
            OP_SEARCH: begin
               for (k = 0; k < n; k++) if (cells[k] == r.value) want.found = 1'b1;
            end
            OP_REMOVE: begin
               for (k = 0; k < n; k++) if (cells[k] == r.value) cells[k] = '0;
            end
            default: begin
               for (k = 0; k < n; k++) if (cells[k] == r.value) cells[k] = r.new_value;
            end
         endcase
         awaited.push_back(want);
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report_mismatch(string msg);
         if (fail_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
         fail_count++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding (status %0b found %0b)",
                                      got.status, got.found));
         end else begin
            want = awaited.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0b, predicted %0b", got.status, want.status));
            if (got.found !== want.found)
               report_mismatch($sformatf("found %0b, predicted %0b", got.found, want.found));
         end
      endtask

      task report_leftovers();
         if (awaited.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited.size()));
      endtask
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        start       = 1'b0;
   req_type     req_payload = '0;
   logic        csr_we      = 1'b0;
   logic        csr_index   = 1'b0;
   logic [4:0]  csr_wdata   = '0;
   logic        busy;
   logic        rsp_strobe;
   rsp_type     rsp_payload;

   psms_scoreboard sb;
   int          items_sent  = 0;
   int          cycle_count = 0;
   bit          gaps_on     = 1'b1;
   logic [31:0] value_pool [4];

   packed_special_matrix_store_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Every signal here is read in the active region straight after the edge. The
   // testbench and the block both update with nonblocking assignments, so the values
   // seen are those that the edge itself sampled. The result is checked before a new
   // transfer is noted: a result on the same edge always belongs to an earlier item.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_response(rsp_payload);
         if (csr_we) sb.write_register(csr_index, csr_wdata);
         if (start && !busy) sb.note_request(req_payload);
      end
   end

   // Watchdog: a hung handshake must not keep the simulation alive for ever.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[packed_special_matrix_store_core] ERROR");
         $finish;
      end
   end

   // Holds start high until the block takes the item. Start stays high afterwards
   // so that a following item can go straight in; otherwise a short idle burst
   // begins, which lands on a random phase of the block's scan.
   task automatic send_item(input req_type item);
      start       <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic do_item(input op_type op, input int unsigned r, input int unsigned c,
                          input logic [31:0] val, input logic [31:0] nval);
      req_type item;
      item.operation = op;
      item.row       = 4'(r);
      item.col       = 4'(c);
      item.value     = val;
      item.new_value = nval;
      send_item(item);
   endtask

   // Registers may only change while the block is idle. The task first waits for the
   // last transfer to be noted, then until every result is back and the block is idle,
   // and makes the write after a further wait.
   task automatic write_csr(input logic idx, input logic [4:0] data);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Values are mostly drawn from a small per-phase pool, so that search, remove and
   // replace find matches. The rest are full-width random values or sign extremes.
   function automatic logic [31:0] pick_value();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return value_pool[$urandom_range(0, 3)];
      if (pick == 7) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return $urandom();
   endfunction

   // Most inserts hit a cell on the current pattern, if the kind defines one; the rest use any row and column.
   function automatic req_type random_item();
      req_type     item;
      int unsigned d, r, pick;
      int          c;
      d              = sb.clamp_dim();
      item.value     = pick_value();
      item.new_value = pick_value();
      item.row       = 4'($urandom_range(0, 15));
      item.col       = 4'($urandom_range(0, 15));
      pick           = $urandom_range(0, 99);
      if (pick < 45) begin
         item.operation = OP_INSERT;
         if ($urandom_range(0, 4) != 0) begin
            r        = $urandom_range(0, d - 1);
            item.row = 4'(r);
            case (sb.kind)
               KIND_DIAG:  item.col = 4'(r);
               KIND_LOWER: item.col = 4'($urandom_range(0, r));
               KIND_UPPER: item.col = 4'($urandom_range(r, d - 1));
               KIND_SYMM:  item.col = 4'($urandom_range(0, d - 1));
               KIND_TRIDI: begin
                  c = int'(r) + int'($urandom_range(0, 2)) - 1;
                  if (c < 0) c = 0;
                  if (c >= int'(d)) c = int'(d) - 1;
                  item.col = 4'(c);
               end
               default: ;
            endcase
         end
      end else if (pick < 70) begin
         item.operation = OP_SEARCH;
      end else if (pick < 85) begin
         item.operation = OP_REMOVE;
      end else begin
         item.operation = OP_REPLACE;
      end
      return item;
   endfunction

   function automatic logic [4:0] random_kind_word();
      logic [2:0] k;
      k = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      return {2'($urandom_range(0, 3)), k};
   endfunction

   // Dimensions favour the extremes and now and then fall outside the legal range,
   // where the block clamps them.
   function automatic logic [4:0] random_dim_word();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 3) return 5'd1;
      if (pick < 6) return 5'd16;
      if (pick == 6) return 5'd0;
      if (pick == 7) return 5'($urandom_range(17, 31));
      return 5'($urandom_range(2, 15));
   endfunction

   initial begin
      int       phase_len;
      req_type  item;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Diagonal kind at full size: sign extremes, an off-pattern cell, all operations.
      do_item(OP_INSERT, 0, 0, 32'h7FFF_FFFF, 32'h0);
      do_item(OP_INSERT, 15, 15, 32'h8000_0000, 32'h0);
      do_item(OP_INSERT, 3, 4, 32'h1234_5678, 32'h0);
      do_item(OP_SEARCH, 0, 0, 32'h8000_0000, 32'h0);
      do_item(OP_REPLACE, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      do_item(OP_REMOVE, 0, 0, 32'h8000_0000, 32'h0);
      do_item(OP_SEARCH, 0, 0, 32'h8000_0000, 32'h0);

      // Tridiagonal: a band cell in the last row, and a cell just off the band.
      write_csr(CSR_KIND, {2'b00, KIND_TRIDI});
      do_item(OP_INSERT, 15, 14, 32'd5, 32'h0);
      do_item(OP_INSERT, 0, 2, 32'd6, 32'h0);
      do_item(OP_SEARCH, 0, 0, 32'd5, 32'h0);

      // Lower triangle with a zero dimension, which acts as a single cell.
      write_csr(CSR_KIND, {2'b11, KIND_LOWER});
      write_csr(CSR_DIM, 5'd0);
      do_item(OP_INSERT, 0, 0, 32'hFFFF_FFFF, 32'h0);
      do_item(OP_INSERT, 1, 0, 32'd7, 32'h0);
      do_item(OP_SEARCH, 0, 0, 32'd0, 32'h0);

      // A dimension above the maximum clamps to the full size.
      write_csr(CSR_DIM, 5'd31);
      do_item(OP_INSERT, 15, 0, 32'd8, 32'h0);
      do_item(OP_INSERT, 0, 15, 32'd8, 32'h0);

      write_csr(CSR_KIND, {2'b00, KIND_UPPER});
      do_item(OP_INSERT, 0, 15, 32'd8, 32'h0);
      do_item(OP_REPLACE, 0, 0, 32'd8, 32'h8000_0000);

      // Symmetric: both orders of a cell share one word.
      write_csr(CSR_KIND, {2'b01, KIND_SYMM});
      write_csr(CSR_DIM, 5'd16);
      do_item(OP_INSERT, 0, 15, 32'd9, 32'h0);
      do_item(OP_INSERT, 15, 0, 32'd10, 32'h0);
      do_item(OP_SEARCH, 0, 0, 32'd9, 32'h0);

      // An undefined kind has no cells and no entries in use.
      write_csr(CSR_KIND, 5'b11111);
      do_item(OP_INSERT, 0, 0, 32'd1, 32'h0);
      do_item(OP_SEARCH, 0, 0, 32'd0, 32'h0);
      do_item(OP_REMOVE, 0, 0, 32'd0, 32'h0);
      do_item(OP_REPLACE, 0, 0, 32'd0, 32'd1);

      // Random phases: usually a fresh configuration, a fresh value pool, then a burst of items.
      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 3) != 0) write_csr(CSR_KIND, random_kind_word());
         if ($urandom_range(0, 3) != 0) write_csr(CSR_DIM, random_dim_word());
         foreach (value_pool[k]) begin
            case ($urandom_range(0, 3))
               0:       value_pool[k] = 32'h0;
               1:       value_pool[k] = $urandom_range(1, 7);
               default: value_pool[k] = $urandom();
            endcase
         end
         phase_len = $urandom_range(15, 50);
         repeat (phase_len) begin
            gaps_on = (items_sent < TOTAL_ITEMS - CALM_ITEMS);
            item    = random_item();
            send_item(item);
         end
      end

      // Drain: every result back and the block idle, then a further margin.
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
      sb.report_leftovers();
      if (sb.fail_count == 0) begin
         $display("[packed_special_matrix_store_core] OK");
      end else begin
         $display("[packed_special_matrix_store_core] ERROR");
      end
      $finish;
   end

endmodule

@@ packed_special_matrix_store_core.f @@
rtl/core/psms_pkg.sv
rtl/core/packed_special_matrix_store_core.sv
tb/sv/tb.sv
